/* sv/rtpdp_pkg.sv */
// ----------------------------------------------------------------------------
// rtpdp_pkg
// Types and constants shared by the RTP H.264 / MPEG-4 depacketizer.
// ----------------------------------------------------------------------------
`default_nettype none

package rtpdp_pkg;

   localparam logic [7:0]  START_CODE_LAST = 8'h01;
   localparam logic [4:0]  NAL_TYPE_SPS    = 5'd7;
   localparam logic [4:0]  NAL_TYPE_FU_A   = 5'd28;
   localparam logic [4:0]  NAL_SINGLE_LAST = 5'd23;
   localparam logic [7:0]  MP4_VOS_CODE    = 8'hB0;
   localparam logic [23:0] MP4_SYNC_PREFIX = 24'h000001;
   localparam logic [3:0]  HDR_LAST_INDEX  = 4'd11;
   localparam logic [2:0]  BURST_MAX       = 3'd5;
   localparam logic [1:0]  LOOKAHEAD_FULL  = 2'd3;

   // one accepted request
   typedef struct packed {
      logic [7:0] in_byte;
      logic       in_last;
   } req_item_type;

   // output bytes caused by one request, first byte in the top lane
   typedef struct packed {
      logic [2:0]  count;
      logic [39:0] bytes;
      logic        last;
      logic [15:0] sequence_num;
      logic [31:0] timestamp;
   } burst_type;

endpackage

`default_nettype wire

/* sv/rtpdp_if.sv */
// ----------------------------------------------------------------------------
// rtpdp channel interfaces
// Request, result and control register channels of the depacketizer.
// ----------------------------------------------------------------------------
`default_nettype none

interface rtpdp_req_if;
   logic       valid;
   logic       ready;
   logic [7:0] in_byte;
   logic       in_last;
   modport source (output valid, output in_byte, output in_last, input ready);
   modport sink   (input valid, input in_byte, input in_last, output ready);
endinterface

interface rtpdp_rsp_if;
   logic        valid;
   logic        ready;
   logic [7:0]  out_byte;
   logic        out_last;
   logic [15:0] out_sequence;
   logic [31:0] out_timestamp;
   modport source (output valid, output out_byte, output out_last,
                   output out_sequence, output out_timestamp, input ready);
   modport sink   (input valid, input out_byte, input out_last,
                   input out_sequence, input out_timestamp, output ready);
endinterface

interface rtpdp_csr_if;
   logic valid;
   logic ready;
   logic codec_mode;
   modport source (output valid, output codec_mode, input ready);
   modport sink   (input valid, input codec_mode, output ready);
endinterface

`default_nettype wire

/* sv/rtpdp_skid.sv */
// ----------------------------------------------------------------------------
// rtpdp_skid
// Two-entry request buffer with a registered ready.
// ----------------------------------------------------------------------------
`default_nettype none

module rtpdp_skid (
   input  wire                     clock,
   input  wire                     reset,
   rtpdp_req_if.sink               req_ch,
   output logic                    head_valid,
   output rtpdp_pkg::req_item_type head_item,
   input  wire                     head_pop
);
   import rtpdp_pkg::*;

   logic         main_valid_ff, main_valid_in;
   logic         skid_valid_ff, skid_valid_in;
   req_item_type main_ff, main_in;
   req_item_type skid_ff, skid_in;
   req_item_type new_item;
   logic         accept;

   assign req_ch.ready = !skid_valid_ff;
   assign accept       = req_ch.valid && !skid_valid_ff;
   assign new_item     = '{in_byte: req_ch.in_byte, in_last: req_ch.in_last};
   assign head_valid   = main_valid_ff;
   assign head_item    = main_ff;

   always_comb begin
      main_valid_in = main_valid_ff;
      skid_valid_in = skid_valid_ff;
      main_in       = main_ff;
      skid_in       = skid_ff;
      if (head_pop || !main_valid_ff) begin
         if (skid_valid_ff) begin
            main_in       = skid_ff;
            main_valid_in = 1'b1;
            skid_valid_in = 1'b0;
         end else if (accept) begin
            main_in       = new_item;
            main_valid_in = 1'b1;
         end else begin
            main_valid_in = 1'b0;
         end
      end else if (accept) begin
         skid_in       = new_item;
         skid_valid_in = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      main_ff <= main_in;
      skid_ff <= skid_in;
      if (reset) begin
         main_valid_ff <= 1'b0;
         skid_valid_ff <= 1'b0;
      end else begin
         main_valid_ff <= main_valid_in;
         skid_valid_ff <= skid_valid_in;
      end
   end

endmodule

`default_nettype wire

/* sv/rtpdp_parser.sv */
// ----------------------------------------------------------------------------
// rtpdp_parser
// RTP header parse and payload rewrite; one request per cycle into a burst, held while the emitter is busy.
// ----------------------------------------------------------------------------
`default_nettype none

module rtpdp_parser (
   input  wire                     clock,
   input  wire                     reset,
   rtpdp_csr_if.sink               csr_ch,
   input  wire                     fire,
   input  rtpdp_pkg::req_item_type item,
   output rtpdp_pkg::burst_type    burst
);
   import rtpdp_pkg::*;

   typedef enum logic [2:0] {
      PH_HDR   = 3'd0,
      PH_CSRC  = 3'd1,
      PH_FIRST = 3'd2,
      PH_FUHDR = 3'd3,
      PH_COPY  = 3'd4,
      PH_DROP  = 3'd5
   } phase_type;

   phase_type   phase_ff, phase_in;
   logic [3:0]  hdr_idx_ff, hdr_idx_in;
   logic [5:0]  csrc_left_ff, csrc_left_in;
   logic        marker_ff, marker_in;
   logic [15:0] seq_ff, seq_in;
   logic [31:0] ts_ff, ts_in;
   logic [2:0]  fu_upper_ff, fu_upper_in;
   logic        awaiting_ff, awaiting_in;
   logic [23:0] look_ff, look_in;
   logic [1:0]  look_cnt_ff, look_cnt_in;
   logic        codec_mode_ff;
   logic [7:0]  b;
   logic [4:0]  nal_type;
   logic [5:0]  csrc_dec;
   logic [2:0]  count;
   logic [39:0] bytes;

   assign csr_ch.ready = 1'b1;
   assign b        = item.in_byte;
   assign nal_type = item.in_byte[4:0];

   always_comb begin
      phase_in     = phase_ff;
      hdr_idx_in   = hdr_idx_ff;
      csrc_left_in = csrc_left_ff;
      marker_in    = marker_ff;
      seq_in       = seq_ff;
      ts_in        = ts_ff;
      fu_upper_in  = fu_upper_ff;
      awaiting_in  = awaiting_ff;
      look_in      = look_ff;
      look_cnt_in  = look_cnt_ff;
      count        = 3'd0;
      bytes        = '0;
      csrc_dec     = (csrc_left_ff != 6'd0) ? csrc_left_ff - 6'd1 : 6'd0;
      unique case (phase_ff)
         PH_HDR: begin
            if (hdr_idx_ff == 4'd0) begin
               csrc_left_in = {b[3:0], 2'b00};
            end else if (hdr_idx_ff == 4'd1) begin
               marker_in = b[7];
            end else if (hdr_idx_ff <= 4'd3) begin
               seq_in = {seq_ff[7:0], b};
            end else if (hdr_idx_ff <= 4'd7) begin
               ts_in = {ts_ff[23:0], b};
            end
            if (hdr_idx_ff >= HDR_LAST_INDEX) begin
               hdr_idx_in = 4'd0;
               phase_in   = (csrc_left_ff != 6'd0) ? PH_CSRC : PH_FIRST;
            end else begin
               hdr_idx_in = hdr_idx_ff + 4'd1;
            end
         end
         PH_CSRC: begin
            csrc_left_in = csrc_dec;
            if (csrc_dec == 6'd0) begin
               phase_in = PH_FIRST;
            end
         end
         PH_FIRST: begin
            if (codec_mode_ff) begin
               if (!awaiting_ff) begin
                  count    = 3'd1;
                  bytes    = {b, 32'h0};
                  phase_in = PH_COPY;
               end else if (look_cnt_ff != LOOKAHEAD_FULL) begin
                  look_in     = {look_ff[15:0], b};
                  look_cnt_in = look_cnt_ff + 2'd1;
               end else if (look_ff == MP4_SYNC_PREFIX && b == MP4_VOS_CODE) begin
                  awaiting_in = 1'b0;
                  count       = 3'd4;
                  bytes       = {look_ff, b, 8'h00};
                  phase_in    = PH_COPY;
               end else begin
                  phase_in = PH_DROP;
               end
            end else begin
               if (awaiting_ff && nal_type != NAL_TYPE_SPS) begin
                  phase_in = PH_DROP;
               end else begin
                  awaiting_in = 1'b0;
                  if (nal_type != 5'd0 && nal_type <= NAL_SINGLE_LAST) begin
                     count    = BURST_MAX;
                     bytes    = {24'h0, START_CODE_LAST, b};
                     phase_in = PH_COPY;
                  end else if (nal_type == NAL_TYPE_FU_A) begin
                     fu_upper_in = b[7:5];
                     phase_in    = PH_FUHDR;
                  end else begin
                     phase_in = PH_DROP;
                  end
               end
            end
         end
         PH_FUHDR: begin
            if (!marker_ff && b[7]) begin
               count = BURST_MAX;
               bytes = {24'h0, START_CODE_LAST, fu_upper_ff, nal_type};
            end
            phase_in = PH_COPY;
         end
         PH_COPY: begin
            count = 3'd1;
            bytes = {b, 32'h0};
         end
         PH_DROP: begin
         end
         default: begin
         end
      endcase
      if (item.in_last) begin
         phase_in     = PH_HDR;
         hdr_idx_in   = 4'd0;
         csrc_left_in = 6'd0;
         look_cnt_in  = 2'd0;
      end
   end

   assign burst = '{count: count, bytes: bytes, last: item.in_last,
                    sequence_num: seq_ff, timestamp: ts_ff};

   always_ff @(posedge clock) begin
      if (fire) begin
         look_ff <= look_in;
      end
      if (reset) begin
         phase_ff      <= PH_HDR;
         hdr_idx_ff    <= 4'd0;
         csrc_left_ff  <= 6'd0;
         marker_ff     <= 1'b0;
         seq_ff        <= 16'd0;
         ts_ff         <= 32'd0;
         fu_upper_ff   <= 3'd0;
         awaiting_ff   <= 1'b1;
         look_cnt_ff   <= 2'd0;
         codec_mode_ff <= 1'b0;
      end else begin
         if (csr_ch.valid) begin
            codec_mode_ff <= csr_ch.codec_mode;
         end
         if (fire) begin
            phase_ff     <= phase_in;
            hdr_idx_ff   <= hdr_idx_in;
            csrc_left_ff <= csrc_left_in;
            marker_ff    <= marker_in;
            seq_ff       <= seq_in;
            ts_ff        <= ts_in;
            fu_upper_ff  <= fu_upper_in;
            awaiting_ff  <= awaiting_in;
            look_cnt_ff  <= look_cnt_in;
         end
      end
   end

   hdr_idx_range: assert property (@(posedge clock) disable iff (reset)
      hdr_idx_ff <= HDR_LAST_INDEX)
      else $error("header index out of range");

   sync_stays_clear: assert property (@(posedge clock) disable iff (reset)
      !awaiting_ff |=> !awaiting_ff)
      else $error("sync wait re-armed without reset");

   last_returns_to_hdr: assert property (@(posedge clock) disable iff (reset)
      fire && item.in_last |=> phase_ff == PH_HDR && hdr_idx_ff == 4'd0)
      else $error("packet end did not restart header parse");

endmodule

`default_nettype wire

/* sv/rtpdp_emitter.sv */
// ----------------------------------------------------------------------------
// rtpdp_emitter
// Result register that sends a burst of up to five bytes, one per cycle while the result channel is ready.
// ----------------------------------------------------------------------------
`default_nettype none

module rtpdp_emitter (
   input  wire                  clock,
   input  wire                  reset,
   input  wire                  head_valid,
   input  rtpdp_pkg::burst_type burst,
   output logic                 fire,
   rtpdp_rsp_if.source          rsp_ch
);
   import rtpdp_pkg::*;

   logic [2:0]  cnt_ff, cnt_in;
   logic [39:0] bytes_ff, bytes_in;
   logic        last_ff, last_in;
   logic [15:0] seq_ff, seq_in;
   logic [31:0] ts_ff, ts_in;
   logic        pop;
   logic        free;

   assign pop  = rsp_ch.valid && rsp_ch.ready;
   assign free = (cnt_ff == 3'd0) || (cnt_ff == 3'd1 && rsp_ch.ready);
   assign fire = head_valid && free;

   assign rsp_ch.valid         = cnt_ff != 3'd0;
   assign rsp_ch.out_byte      = bytes_ff[39:32];
   assign rsp_ch.out_last      = last_ff && cnt_ff == 3'd1;
   assign rsp_ch.out_sequence  = seq_ff;
   assign rsp_ch.out_timestamp = ts_ff;

   always_comb begin
      cnt_in   = cnt_ff;
      bytes_in = bytes_ff;
      last_in  = last_ff;
      seq_in   = seq_ff;
      ts_in    = ts_ff;
      if (fire) begin
         cnt_in   = burst.count;
         bytes_in = burst.bytes;
         last_in  = burst.last;
         seq_in   = burst.sequence_num;
         ts_in    = burst.timestamp;
      end else if (pop) begin
         cnt_in   = cnt_ff - 3'd1;
         bytes_in = {bytes_ff[31:0], 8'h00};
      end
   end

   always_ff @(posedge clock) begin
      bytes_ff <= bytes_in;
      last_ff  <= last_in;
      seq_ff   <= seq_in;
      ts_ff    <= ts_in;
      if (reset) begin
         cnt_ff <= 3'd0;
      end else begin
         cnt_ff <= cnt_in;
      end
   end

   burst_bounded: assert property (@(posedge clock) disable iff (reset)
      cnt_ff <= BURST_MAX)
      else $error("burst count above maximum");

   no_overwrite: assert property (@(posedge clock) disable iff (reset)
      fire |-> cnt_ff == 3'd0 || (cnt_ff == 3'd1 && pop))
      else $error("burst loaded over pending bytes");

   pop_counts_down: assert property (@(posedge clock) disable iff (reset)
      pop && cnt_ff > 3'd1 |=> cnt_ff == $past(cnt_ff) - 3'd1)
      else $error("burst count did not step down");

endmodule

`default_nettype wire

/* sv/rtp_h264_mpeg4_depacketizer.sv */
// Path: a request waits in the skid buffer, its bytes in the result register.
// Throughput: one request per cycle when each causes at most one byte and
//   the result channel is ready; a request that causes n bytes (start code
//   bursts, up to 5) holds the single result register until all n are sent.
// Reset: synchronous; parser restarts at the RTP header, H.264 mode is
//   selected and the stream waits again for an SPS or VOS.
// ----------------------------------------------------------------------------
// rtp_h264_mpeg4_depacketizer
// RTP to H.264 Annex B / MPEG-4 elementary stream depacketizer.
// ----------------------------------------------------------------------------
`default_nettype none

module rtp_h264_mpeg4_depacketizer (
   input  wire         clock,
   input  wire         reset,
   rtpdp_req_if.sink   req_ch,
   rtpdp_rsp_if.source rsp_ch,
   rtpdp_csr_if.sink   csr_ch
);
   import rtpdp_pkg::*;

   logic         head_valid;
   req_item_type head_item;
   logic         fire;
   burst_type    burst;

   rtpdp_skid u_skid (
      .clock      (clock),
      .reset      (reset),
      .req_ch     (req_ch),
      .head_valid (head_valid),
      .head_item  (head_item),
      .head_pop   (fire)
   );

   rtpdp_parser u_parser (
      .clock  (clock),
      .reset  (reset),
      .csr_ch (csr_ch),
      .fire   (fire),
      .item   (head_item),
      .burst  (burst)
   );

   rtpdp_emitter u_emitter (
      .clock      (clock),
      .reset      (reset),
      .head_valid (head_valid),
      .burst      (burst),
      .fire       (fire),
      .rsp_ch     (rsp_ch)
   );

endmodule

`default_nettype wire

/* dv/rtpdp_es_checker.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rtpdp_es_checker
// Watches the request, result and control channels of the depacketizer,
// rebuilds the expected elementary stream byte by byte from each accepted
// request and compares every accepted result against the oldest expected one.
// ----------------------------------------------------------------------------

module rtpdp_es_checker (
   input  wire   clock,
   input  wire   reset,
   rtpdp_req_if  req_ch,
   rtpdp_rsp_if  rsp_ch,
   rtpdp_csr_if  csr_ch,
   output int    fail_count,
   output int    pending_count
);
   import rtpdp_pkg::*;

   typedef enum logic [2:0] {
      ST_HEADER,
      ST_CSRC,
      ST_NAL_HDR,
      ST_FU_HDR,
      ST_COPY,
      ST_DROP
   } parse_state_type;

   typedef struct packed {
      logic [7:0]  data;
      logic        last;
      logic [15:0] seq;
      logic [31:0] ts;
   } es_byte_type;

   parse_state_type state;
   logic [3:0]      hdr_idx;
   logic [5:0]      csrc_left;
   logic            marker;
   logic [15:0]     rtp_seq;
   logic [31:0]     rtp_ts;
   logic [2:0]      fu_f_nri;
   logic            awaiting_sync;
   logic [23:0]     sync_window;
   logic [1:0]      window_fill;
   logic            codec_mode;
   es_byte_type     es_expected[$];

   task automatic emit(input logic [7:0] b);
      es_byte_type e;
      e.data = b;
      e.last = 1'b0;
      e.seq  = rtp_seq;
      e.ts   = rtp_ts;
      es_expected.push_back(e);
   endtask

   task automatic emit_start_code();
      emit(8'h00);
      emit(8'h00);
      emit(8'h00);
      emit(START_CODE_LAST);
   endtask

   task automatic predict_request(input logic [7:0] b, input logic l);
      int         n_before;
      logic [4:0] nal_type;
      n_before = es_expected.size();
      nal_type = b[4:0];
      case (state)
         ST_HEADER: begin
            case (hdr_idx)
               4'd0: csrc_left = {b[3:0], 2'b00};
               4'd1: marker = b[7];
               4'd2, 4'd3: rtp_seq = {rtp_seq[7:0], b};
               4'd4, 4'd5, 4'd6, 4'd7: rtp_ts = {rtp_ts[23:0], b};
               default: ;
            endcase
            if (hdr_idx >= HDR_LAST_INDEX) begin
               hdr_idx = '0;
               state = (csrc_left != '0) ? ST_CSRC : ST_NAL_HDR;
            end else begin
               hdr_idx = hdr_idx + 4'd1;
            end
         end
         ST_CSRC: begin
            if (csrc_left != '0) csrc_left = csrc_left - 6'd1;
            if (csrc_left == '0) state = ST_NAL_HDR;
         end
         ST_NAL_HDR: begin
            if (codec_mode) begin
               if (!awaiting_sync) begin
                  emit(b);
                  state = ST_COPY;
               end else if (window_fill < LOOKAHEAD_FULL) begin
                  sync_window = {sync_window[15:0], b};
                  window_fill = window_fill + 2'd1;
               end else if (sync_window == MP4_SYNC_PREFIX && b == MP4_VOS_CODE) begin
                  awaiting_sync = 1'b0;
                  emit(sync_window[23:16]);
                  emit(sync_window[15:8]);
                  emit(sync_window[7:0]);
                  emit(b);
                  state = ST_COPY;
               end else begin
                  state = ST_DROP;
               end
            end else if (awaiting_sync && nal_type != NAL_TYPE_SPS) begin
               state = ST_DROP;
            end else begin
               awaiting_sync = 1'b0;
               if (nal_type != '0 && nal_type <= NAL_SINGLE_LAST) begin
                  emit_start_code();
                  emit(b);
                  state = ST_COPY;
               end else if (nal_type == NAL_TYPE_FU_A) begin
                  fu_f_nri = b[7:5];
                  state = ST_FU_HDR;
               end else begin
                  state = ST_DROP;
               end
            end
         end
         ST_FU_HDR: begin
            if (!marker && b[7]) begin
               emit_start_code();
               emit({fu_f_nri, b[4:0]});
            end
            state = ST_COPY;
         end
         ST_COPY: emit(b);
         default: ;
      endcase
      if (l) begin
         if (es_expected.size() > n_before)
            es_expected[es_expected.size() - 1].last = 1'b1;
         state = ST_HEADER;
         hdr_idx = '0;
         csrc_left = '0;
         window_fill = '0;
      end
   endtask

   task automatic check_es_byte();
      es_byte_type want;
      if (es_expected.size() == 0) begin
         fail_count++;
         if (fail_count <= 10)
            $display("es_check: unexpected result byte=%02h last=%0b seq=%04h ts=%08h",
                     rsp_ch.out_byte, rsp_ch.out_last, rsp_ch.out_sequence,
                     rsp_ch.out_timestamp);
      end else begin
         want = es_expected.pop_front();
         if (rsp_ch.out_byte !== want.data || rsp_ch.out_last !== want.last ||
             rsp_ch.out_sequence !== want.seq || rsp_ch.out_timestamp !== want.ts) begin
            fail_count++;
            if (fail_count <= 10)
               $display("es_check: mismatch exp %02h/%0b/%04h/%08h got %02h/%0b/%04h/%08h",
                        want.data, want.last, want.seq, want.ts,
                        rsp_ch.out_byte, rsp_ch.out_last, rsp_ch.out_sequence,
                        rsp_ch.out_timestamp);
         end
      end
   endtask

   always @(posedge clock) begin
      if (reset) begin
         state         = ST_HEADER;
         hdr_idx       = '0;
         csrc_left     = '0;
         marker        = 1'b0;
         rtp_seq       = '0;
         rtp_ts        = '0;
         fu_f_nri      = '0;
         awaiting_sync = 1'b1;
         sync_window   = '0;
         window_fill   = '0;
         codec_mode    = 1'b0;
         es_expected.delete();
      end else begin
         if (csr_ch.valid === 1'b1 && csr_ch.ready === 1'b1)
            codec_mode = csr_ch.codec_mode;
         if (req_ch.valid === 1'b1 && req_ch.ready === 1'b1)
            predict_request(req_ch.in_byte, req_ch.in_last);
         if (rsp_ch.valid === 1'b1 && rsp_ch.ready === 1'b1)
            check_es_byte();
      end
      pending_count = es_expected.size();
   end

endmodule

/* dv/tb_rtp_h264_mpeg4_depacketizer.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_rtp_h264_mpeg4_depacketizer
// Feeds RTP packets (directed corner cases, then random well-formed and
// truncated packets) through the depacketizer in H.264 and MPEG-4 modes
// under several request idle and result stall patterns; the stream checker
// scores the output.
// ----------------------------------------------------------------------------

module tb_rtp_h264_mpeg4_depacketizer;
   import rtpdp_pkg::*;

   typedef logic [7:0] octet_q_type[$];

   logic clock = 1'b0;
   logic reset = 1'b1;
   int   fail_count;
   int   pending_count;
   int   req_idle_pct = 0;
   int   rsp_stall_pct = 0;
   int   bytes_sent = 0;
   int   idle_tbl[4] = '{0, 88, 0, 32};
   int   stall_tbl[4] = '{0, 0, 88, 32};

   rtpdp_req_if req_ch();
   rtpdp_rsp_if rsp_ch();
   rtpdp_csr_if csr_ch();

   rtp_h264_mpeg4_depacketizer DUT (
      .clock  (clock),
      .reset  (reset),
      .req_ch (req_ch),
      .rsp_ch (rsp_ch),
      .csr_ch (csr_ch)
   );

   rtpdp_es_checker es_check (
      .clock         (clock),
      .reset         (reset),
      .req_ch        (req_ch),
      .rsp_ch        (rsp_ch),
      .csr_ch        (csr_ch),
      .fail_count    (fail_count),
      .pending_count (pending_count)
   );

   always #5 clock = ~clock;

   initial begin
      rsp_ch.ready = 1'b0;
      forever begin
         @(negedge clock);
         rsp_ch.ready <= ($urandom_range(99) >= rsp_stall_pct);
      end
   end

   initial begin
      #5_000_000;
      $display("tb_rtp_h264_mpeg4_depacketizer: FAIL");
      $finish;
   end

   task automatic send_byte(input logic [7:0] b, input logic l);
      while ($urandom_range(99) < req_idle_pct) begin
         req_ch.valid <= 1'b0;
         @(negedge clock);
      end
      req_ch.valid   <= 1'b1;
      req_ch.in_byte <= b;
      req_ch.in_last <= l;
      do @(posedge clock); while (req_ch.ready !== 1'b1);
      @(negedge clock);
      bytes_sent++;
   endtask

   // header + CSRC list + body, optionally cut short after cut bytes
   task automatic send_pkt(input logic [3:0] cc, input logic mk, input logic [15:0] seq,
                           input logic [31:0] ts, input octet_q_type body, input int cut);
      octet_q_type q;
      logic [7:0]  b0;
      logic [7:0]  b1;
      b0 = 8'($urandom);
      b0[3:0] = cc;
      b1 = 8'($urandom);
      b1[7] = mk;
      q = '{b0, b1, seq[15:8], seq[7:0], ts[31:24], ts[23:16], ts[15:8], ts[7:0]};
      repeat (4 + 4 * cc) q.push_back(8'($urandom));
      foreach (body[i]) q.push_back(body[i]);
      if (cut > 0 && cut < q.size()) q = q[0:cut - 1];
      foreach (q[i]) send_byte(q[i], i == q.size() - 1);
   endtask

   task automatic send_random_packet(input logic mode);
      octet_q_type body;
      logic [3:0]  cc;
      logic        mk;
      logic [7:0]  nal;
      logic [7:0]  fu;
      int          pick;
      int          cut;
      pick = $urandom_range(19);
      cc   = (pick == 0) ? 4'hF : (pick < 4) ? 4'($urandom_range(3, 1)) : 4'h0;
      mk   = 1'($urandom);
      nal  = 8'($urandom);
      fu   = 8'($urandom);
      if (!mode) begin
         case ($urandom_range(9))
            0, 1, 2, 3: begin
               nal[4:0] = 5'($urandom_range(NAL_SINGLE_LAST, 1));
               body.push_back(nal);
            end
            4, 5: begin
               mk = 1'b0;
               nal[4:0] = NAL_TYPE_FU_A;
               fu[7] = 1'b1;
               body.push_back(nal);
               body.push_back(fu);
            end
            6: begin
               mk = 1'b0;
               nal[4:0] = NAL_TYPE_FU_A;
               fu[7] = 1'b0;
               body.push_back(nal);
               body.push_back(fu);
            end
            7: begin
               mk = 1'b1;
               nal[4:0] = NAL_TYPE_FU_A;
               body.push_back(nal);
               body.push_back(fu);
            end
            8: begin
               nal[4:0] = 5'($urandom_range(31, NAL_SINGLE_LAST + 1));
               if (nal[4:0] == NAL_TYPE_FU_A) nal[4:0] = '0;
               body.push_back(nal);
            end
            default: ;
         endcase
      end
      repeat ($urandom_range(8)) body.push_back(8'($urandom));
      cut = ($urandom_range(7) == 0) ? $urandom_range(30, 1) : 0;
      send_pkt(cc, mk, 16'($urandom), $urandom, body, cut);
   endtask

   task automatic settle();
      req_ch.valid <= 1'b0;
      while (pending_count != 0) @(negedge clock);
      repeat (8) @(negedge clock);
   endtask

   task automatic set_mode(input logic m);
      settle();
      csr_ch.valid      <= 1'b1;
      csr_ch.codec_mode <= m;
      do @(posedge clock); while (csr_ch.ready !== 1'b1);
      @(negedge clock);
      csr_ch.valid <= 1'b0;
   endtask

   initial begin
      int   phase_i;
      int   mark;
      logic mode_sel;
      req_ch.valid      = 1'b0;
      req_ch.in_byte    = '0;
      req_ch.in_last    = 1'b0;
      csr_ch.valid      = 1'b0;
      csr_ch.codec_mode = 1'b0;
      repeat (3) @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);

      // H.264, no SPS seen yet: dropped
      send_pkt(4'd0, 1'b0, 16'h0001, 32'h1, '{8'h7C, 8'h85, 8'h22}, 0);

      // MPEG-4 sync wait: bad code, then VOS behind a CSRC list
      set_mode(1'b1);
      send_pkt(4'd0, 1'b0, 16'h0003, 32'h3, '{8'h00, 8'h00, 8'h01, 8'hB1, 8'h33}, 0);
      send_pkt(4'd2, 1'b1, 16'hFFFF, 32'hFFFF_FFFF,
               '{8'h00, 8'h00, 8'h01, 8'hB0, 8'hAA, 8'hBB}, 0);

      // H.264 NAL types and FU-A variants
      set_mode(1'b0);
      send_pkt(4'd0, 1'b0, 16'h1234, 32'h1234_5678, '{8'h67, 8'h42, 8'h00}, 0);
      send_pkt(4'd0, 1'b1, 16'h1235, 32'h1234_5679, '{8'hF7, 8'h80}, 0);
      send_pkt(4'd0, 1'b0, 16'h1239, 32'h9, '{8'h7C, 8'h85, 8'h01, 8'h02}, 0);
      send_pkt(4'd0, 1'b1, 16'h123B, 32'hB, '{8'h5C, 8'hC5, 8'h04}, 0);

      for (phase_i = 0; phase_i < 4; phase_i++) begin
         mode_sel = phase_i[0];
         set_mode(mode_sel);
         req_idle_pct  = idle_tbl[phase_i];
         rsp_stall_pct = stall_tbl[phase_i];
         mark = bytes_sent;
         while (bytes_sent - mark < 20) send_random_packet(mode_sel);
      end

      settle();
      if (fail_count == 0 && pending_count == 0)
         $display("tb_rtp_h264_mpeg4_depacketizer: PASS");
      else
         $display("tb_rtp_h264_mpeg4_depacketizer: FAIL");
      $finish;
   end

endmodule

/* sim.f */
sv/rtpdp_pkg.sv
sv/rtpdp_if.sv
sv/rtpdp_skid.sv
sv/rtpdp_parser.sv
sv/rtpdp_emitter.sv
sv/rtp_h264_mpeg4_depacketizer.sv
dv/rtpdp_es_checker.sv
dv/tb_rtp_h264_mpeg4_depacketizer.sv
